>>> design/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared widths, opcodes, status codes and the result record of the
// client frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

    localparam int unsigned LEN_W = 21;
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = LEN_W'(64 * 1024);

    localparam logic [3:0] OP_CONT  = 4'h0;
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_BIN   = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;
    localparam logic [3:0] OP_PONG  = 4'hA;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_UNMASKED   = 3'd1;
    localparam logic [2:0] ST_TOO_LONG   = 3'd2;
    localparam logic [2:0] ST_ORPHAN     = 3'd3;
    localparam logic [2:0] ST_UNKNOWN_OP = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       data_present;
        logic [3:0] frame_opcode;
        logic       fin_flag;
        logic       frame_last;
        logic       message_last;
        logic [2:0] status;
    } wsd_result_t;

endpackage

>>> design/wsd_parser.sv
// ----------------------------------------------------------------------------
// wsd_parser
// Frame header walker and payload unmasker: one byte per request, at most
// one result per byte, error and close halt latched until reset.
// ----------------------------------------------------------------------------
module wsd_parser (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write_en,
    input  logic [wsd_pkg::LEN_W-1:0]  cfg_write_data,
    input  logic                       accept,
    input  logic [7:0]                 in_byte,
    output logic                       res_valid,
    output wsd_pkg::wsd_result_t       res
);

    typedef enum logic [2:0] {
        PH_HDR0  = 3'd0,
        PH_HDR1  = 3'd1,
        PH_EXT16 = 3'd2,
        PH_EXT64 = 3'd3,
        PH_KEY   = 3'd4,
        PH_DATA  = 3'd5
    } phase_t;

    phase_t                      phase_reg,     phase_next;
    logic [3:0]                  hdr_cnt_reg,   hdr_cnt_next;
    logic [3:0]                  opcode_reg,    opcode_next;
    logic                        fin_reg,       fin_next;
    logic [63:0]                 len_acc_reg,   len_acc_next;
    logic [wsd_pkg::LEN_W-1:0]   remain_reg,    remain_next;
    logic [31:0]                 key_reg,       key_next;
    logic [1:0]                  mask_idx_reg,  mask_idx_next;
    logic                        msg_active_reg, msg_active_next;
    logic                        halted_reg,    halted_next;
    logic [wsd_pkg::LEN_W-1:0]   max_len_reg;

    logic [63:0]                 len_shift;
    logic [63:0]                 len_cand;
    logic                        too_long;
    logic [31:0]                 key_shift;
    logic [3:0]                  cnt_inc;
    logic [wsd_pkg::LEN_W-1:0]   remain_dec;
    logic [7:0]                  key_byte;
    logic                        op_known;
    logic                        len_end;

    function automatic wsd_pkg::wsd_result_t make_res(
        input logic [7:0] data,
        input logic       present,
        input logic       flast,
        input logic [2:0] status,
        input logic [3:0] op,
        input logic       fin
    );
        wsd_pkg::wsd_result_t r;
        r.data_byte    = data;
        r.data_present = present;
        r.frame_opcode = op;
        r.fin_flag     = fin;
        r.frame_last   = flast;
        r.message_last = flast & fin & (op <= wsd_pkg::OP_BIN);
        r.status       = status;
        return r;
    endfunction

    assign len_shift  = {len_acc_reg[55:0], in_byte};
    assign len_cand   = (phase_reg == PH_HDR1) ? {57'd0, in_byte[6:0]} : len_shift;
    assign too_long   = (|len_cand[63:wsd_pkg::LEN_W])
                        || (len_cand[wsd_pkg::LEN_W-1:0] > max_len_reg);
    assign key_shift  = {key_reg[23:0], in_byte};
    assign cnt_inc    = hdr_cnt_reg + 4'd1;
    assign remain_dec = remain_reg - wsd_pkg::LEN_W'(1);
    assign key_byte   = 8'(key_reg >> {~mask_idx_reg, 3'b000});

    always_comb
    begin
        unique case (opcode_reg)
            wsd_pkg::OP_CONT, wsd_pkg::OP_TEXT, wsd_pkg::OP_BIN,
            wsd_pkg::OP_CLOSE, wsd_pkg::OP_PING, wsd_pkg::OP_PONG: op_known = 1'b1;
            default:                                               op_known = 1'b0;
        endcase
    end

    always_comb
    begin
        phase_next      = phase_reg;
        hdr_cnt_next    = hdr_cnt_reg;
        opcode_next     = opcode_reg;
        fin_next        = fin_reg;
        len_acc_next    = len_acc_reg;
        remain_next     = remain_reg;
        key_next        = key_reg;
        mask_idx_next   = mask_idx_reg;
        msg_active_next = msg_active_reg;
        halted_next     = halted_reg;
        res_valid       = 1'b0;
        res             = '0;
        len_end         = 1'b0;

        if (accept && !halted_reg)
        begin
            unique case (phase_reg)
                PH_HDR0:
                begin
                    fin_next    = in_byte[7];
                    opcode_next = in_byte[3:0];
                    phase_next  = PH_HDR1;
                end
                PH_HDR1:
                begin
                    if (!in_byte[7])
                    begin
                        res_valid   = 1'b1;
                        res         = make_res(8'd0, 1'b0, 1'b0, wsd_pkg::ST_UNMASKED,
                                               opcode_reg, fin_reg);
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        len_acc_next = '0;
                        hdr_cnt_next = '0;
                        if (in_byte[6:0] == 7'd126)
                            phase_next = PH_EXT16;
                        else if (in_byte[6:0] == 7'd127)
                            phase_next = PH_EXT64;
                        else
                        begin
                            len_acc_next = len_cand;
                            len_end      = 1'b1;
                        end
                    end
                end
                PH_EXT16, PH_EXT64:
                begin
                    len_acc_next = len_shift;
                    hdr_cnt_next = cnt_inc;
                    if (cnt_inc == ((phase_reg == PH_EXT16) ? 4'd2 : 4'd8))
                        len_end = 1'b1;
                end
                PH_KEY:
                begin
                    key_next     = key_shift;
                    hdr_cnt_next = cnt_inc;
                    if (cnt_inc >= 4'd4)
                    begin
                        hdr_cnt_next  = '0;
                        mask_idx_next = '0;
                        if (opcode_reg == wsd_pkg::OP_CONT && !msg_active_reg)
                        begin
                            res_valid   = 1'b1;
                            res         = make_res(8'd0, 1'b0, 1'b0, wsd_pkg::ST_ORPHAN,
                                                   opcode_reg, fin_reg);
                            halted_next = 1'b1;
                        end
                        else if (!op_known)
                        begin
                            res_valid   = 1'b1;
                            res         = make_res(8'd0, 1'b0, 1'b0, wsd_pkg::ST_UNKNOWN_OP,
                                                   opcode_reg, fin_reg);
                            halted_next = 1'b1;
                        end
                        else
                        begin
                            if (opcode_reg == wsd_pkg::OP_TEXT
                                || opcode_reg == wsd_pkg::OP_BIN)
                                msg_active_next = 1'b1;
                            if (remain_reg == '0)
                            begin
                                res_valid  = 1'b1;
                                res        = make_res(8'd0, 1'b0, 1'b1, wsd_pkg::ST_OK,
                                                      opcode_reg, fin_reg);
                                phase_next = PH_HDR0;
                                if (opcode_reg <= wsd_pkg::OP_BIN && fin_reg)
                                    msg_active_next = 1'b0;
                                if (opcode_reg == wsd_pkg::OP_CLOSE)
                                    halted_next = 1'b1;
                            end
                            else
                                phase_next = PH_DATA;
                        end
                    end
                end
                PH_DATA:
                begin
                    mask_idx_next = mask_idx_reg + 2'd1;
                    remain_next   = remain_dec;
                    res_valid     = 1'b1;
                    res           = make_res(in_byte ^ key_byte, 1'b1, remain_dec == '0,
                                             wsd_pkg::ST_OK, opcode_reg, fin_reg);
                    if (remain_dec == '0)
                    begin
                        phase_next = PH_HDR0;
                        if (opcode_reg <= wsd_pkg::OP_BIN && fin_reg)
                            msg_active_next = 1'b0;
                        if (opcode_reg == wsd_pkg::OP_CLOSE)
                            halted_next = 1'b1;
                    end
                end
                default:
                    phase_next = PH_HDR0;
            endcase

            // length complete: check limit, then collect the key
            if (len_end)
            begin
                if (too_long)
                begin
                    res_valid   = 1'b1;
                    res         = make_res(8'd0, 1'b0, 1'b0, wsd_pkg::ST_TOO_LONG,
                                           opcode_reg, fin_reg);
                    halted_next = 1'b1;
                end
                else
                begin
                    remain_next  = len_cand[wsd_pkg::LEN_W-1:0];
                    hdr_cnt_next = '0;
                    key_next     = '0;
                    phase_next   = PH_KEY;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HDR0;
            hdr_cnt_reg    <= '0;
            opcode_reg     <= '0;
            fin_reg        <= 1'b0;
            len_acc_reg    <= '0;
            remain_reg     <= '0;
            key_reg        <= '0;
            mask_idx_reg   <= '0;
            msg_active_reg <= 1'b0;
            halted_reg     <= 1'b0;
            max_len_reg    <= wsd_pkg::MAX_LEN_RESET;
        end
        else
        begin
            phase_reg      <= phase_next;
            hdr_cnt_reg    <= hdr_cnt_next;
            opcode_reg     <= opcode_next;
            fin_reg        <= fin_next;
            len_acc_reg    <= len_acc_next;
            remain_reg     <= remain_next;
            key_reg        <= key_next;
            mask_idx_reg   <= mask_idx_next;
            msg_active_reg <= msg_active_next;
            halted_reg     <= halted_next;
            if (cfg_write_en)
                max_len_reg <= cfg_write_data;
        end
    end

endmodule

>>> design/websocket_client_frame_deframer.sv
// A result goes to the output register, or to the skid register while the output
// stalls. Throughput: one byte per cycle while the skid is empty; parser state
// updates in the cycle of the request, and a two-entry output stage (output
// register plus skid) keeps input open while one result waits. rst_n clears
// parser state, restores max_len_reg to 65536 and empties the output stage.
// ----------------------------------------------------------------------------
// websocket_client_frame_deframer
// Client-to-server frame deframer: header decode, length check, unmasking
// and message tracking, with a skid-buffered result channel.
// ----------------------------------------------------------------------------
module websocket_client_frame_deframer (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write_en,
    input  logic [wsd_pkg::LEN_W-1:0]  cfg_write_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [7:0]                 in_byte,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [7:0]                 data_byte,
    output logic                       data_present,
    output logic [3:0]                 frame_opcode,
    output logic                       fin_flag,
    output logic                       frame_last,
    output logic                       message_last,
    output logic [2:0]                 status
);

    logic                  accept;
    logic                  res_valid;
    wsd_pkg::wsd_result_t  res;
    logic                  push;

    logic                  out_valid_reg;
    logic                  skid_valid_reg;
    wsd_pkg::wsd_result_t  out_reg;
    wsd_pkg::wsd_result_t  skid_reg;

    assign in_ready = !skid_valid_reg;
    assign accept   = in_valid && in_ready;
    assign push     = accept && res_valid;

    wsd_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .accept         (accept),
        .in_byte        (in_byte),
        .res_valid      (res_valid),
        .res            (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && !out_ready)
        begin
            if (push)
                skid_valid_reg <= 1'b1;
        end
        else if (skid_valid_reg)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
        else
            out_valid_reg <= push;
    end

    always_ff @(posedge clk)
    begin
        if (out_valid_reg && !out_ready)
        begin
            if (push)
                skid_reg <= res;
        end
        else if (skid_valid_reg)
            out_reg <= skid_reg;
        else if (push)
            out_reg <= res;
    end

    assign out_valid    = out_valid_reg;
    assign data_byte    = out_reg.data_byte;
    assign data_present = out_reg.data_present;
    assign frame_opcode = out_reg.frame_opcode;
    assign fin_flag     = out_reg.fin_flag;
    assign frame_last   = out_reg.frame_last;
    assign message_last = out_reg.message_last;
    assign status       = out_reg.status;

endmodule

>>> design/wsd_checker.sv
// ----------------------------------------------------------------------------
// wsd_checker
// Port-level checks of the deframer result channel, bound to the top level.
// ----------------------------------------------------------------------------
module wsd_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  data_byte,
    input  logic        data_present,
    input  logic [3:0]  frame_opcode,
    input  logic        fin_flag,
    input  logic        frame_last,
    input  logic        message_last,
    input  logic [2:0]  status
);

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(data_byte)
            && $stable(status) && $stable(frame_last))
        else $error("stalled result changed");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !data_present |-> data_byte == 8'd0)
        else $error("data_byte nonzero without payload");

    a_msg_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && message_last |-> frame_last && fin_flag
            && frame_opcode <= wsd_pkg::OP_BIN)
        else $error("message_last outside a final data frame");

    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != wsd_pkg::ST_OK |-> !frame_last && !data_present)
        else $error("error result marked as data or frame end");

    a_halt_after_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && status != wsd_pkg::ST_OK |=> !out_valid)
        else $error("result after error");

endmodule

bind websocket_client_frame_deframer wsd_checker u_wsd_checker (.*);

>>> test/websocket_client_frame_deframer_tb.sv
// ----------------------------------------------------------------------------
// websocket_client_frame_deframer_tb
// Streams masked client frames into the deframer through a random-gap sender
// and drains results through a randomly stalling receiver. A scoreboard class
// walks the same byte stream through its own header parser and unmasker,
// queues the results it predicts and checks each accepted result against the
// oldest one. The payload limit is changed between phases while the block is
// idle, and the run ends with one halting frame followed by ignored bytes.
// ----------------------------------------------------------------------------
module websocket_client_frame_deframer_tb;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned HOLD_CYCLES = 64;
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;
    localparam int unsigned LEN_LIMIT_TOP = 1048576;

    typedef enum logic [2:0] {
        AWAIT_HEAD,
        AWAIT_LEN,
        EXT_LEN16,
        EXT_LEN64,
        MASK_KEY,
        PAYLOAD
    } parse_phase_t;

    typedef enum int {LEN_SHORT, LEN_WIDE16, LEN_WIDE64} len_form_t;

    typedef enum int {
        END_CLOSE,
        END_UNMASKED,
        END_TOO_LONG,
        END_ORPHAN,
        END_BAD_OPCODE
    } ending_t;

    class deframe_scoreboard;
        logic [wsd_pkg::LEN_W-1:0] len_limit;
        parse_phase_t              phase;
        logic [3:0]                hdr_count;
        logic [3:0]                opcode;
        logic                      fin;
        logic [63:0]               len_acc;
        logic [wsd_pkg::LEN_W-1:0] remaining;
        logic [31:0]               key;
        logic [1:0]                key_idx;
        logic                      in_message;
        logic                      stopped;
        wsd_pkg::wsd_result_t      want_results[$];
        int unsigned               fail_count;

        function new();
            len_limit  = wsd_pkg::MAX_LEN_RESET;
            phase      = AWAIT_HEAD;
            hdr_count  = '0;
            opcode     = '0;
            fin        = 1'b0;
            len_acc    = '0;
            remaining  = '0;
            key        = '0;
            key_idx    = '0;
            in_message = 1'b0;
            stopped    = 1'b0;
            fail_count = 0;
        endfunction

        function void queue_result(input logic [7:0] value, input logic present,
                                   input logic flast, input logic [2:0] code);
            wsd_pkg::wsd_result_t r;
            r.data_byte    = value;
            r.data_present = present;
            r.frame_opcode = opcode;
            r.fin_flag     = fin;
            r.frame_last   = flast;
            r.message_last = flast && fin && (opcode <= wsd_pkg::OP_BIN);
            r.status       = code;
            want_results.insert(want_results.size(), r);
        endfunction

        function void abort_frame(input logic [2:0] code);
            queue_result(8'h00, 1'b0, 1'b0, code);
            stopped = 1'b1;
        endfunction

        function void close_out_frame();
            if (opcode <= wsd_pkg::OP_BIN && fin)
                in_message = 1'b0;
            if (opcode == wsd_pkg::OP_CLOSE)
                stopped = 1'b1;
            phase = AWAIT_HEAD;
        endfunction

        function void length_complete();
            if (len_acc > 64'(len_limit))
                abort_frame(wsd_pkg::ST_TOO_LONG);
            else
            begin
                remaining = len_acc[wsd_pkg::LEN_W-1:0];
                hdr_count = '0;
                key       = '0;
                phase     = MASK_KEY;
            end
        endfunction

        function void take_byte(input logic [7:0] b);
            logic [7:0] key_byte;
            logic       last;
            if (stopped)
                return;
            case (phase)
                AWAIT_HEAD:
                begin
                    fin    = b[7];
                    opcode = b[3:0];
                    phase  = AWAIT_LEN;
                end
                AWAIT_LEN:
                begin
                    if (!b[7])
                        abort_frame(wsd_pkg::ST_UNMASKED);
                    else
                    begin
                        len_acc   = '0;
                        hdr_count = '0;
                        if (b[6:0] == LEN_EXT16)
                            phase = EXT_LEN16;
                        else if (b[6:0] == LEN_EXT64)
                            phase = EXT_LEN64;
                        else
                        begin
                            len_acc = 64'(b[6:0]);
                            length_complete();
                        end
                    end
                end
                EXT_LEN16, EXT_LEN64:
                begin
                    len_acc   = {len_acc[55:0], b};
                    hdr_count = hdr_count + 4'd1;
                    if (hdr_count == ((phase == EXT_LEN16) ? 4'd2 : 4'd8))
                        length_complete();
                end
                MASK_KEY:
                begin
                    key       = {key[23:0], b};
                    hdr_count = hdr_count + 4'd1;
                    if (hdr_count == 4'd4)
                    begin
                        hdr_count = '0;
                        key_idx   = '0;
                        if (opcode == wsd_pkg::OP_CONT && !in_message)
                            abort_frame(wsd_pkg::ST_ORPHAN);
                        else if (!(opcode inside {wsd_pkg::OP_CONT, wsd_pkg::OP_TEXT,
                                                  wsd_pkg::OP_BIN, wsd_pkg::OP_CLOSE,
                                                  wsd_pkg::OP_PING, wsd_pkg::OP_PONG}))
                            abort_frame(wsd_pkg::ST_UNKNOWN_OP);
                        else
                        begin
                            if (opcode == wsd_pkg::OP_TEXT || opcode == wsd_pkg::OP_BIN)
                                in_message = 1'b1;
                            if (remaining == '0)
                            begin
                                queue_result(8'h00, 1'b0, 1'b1, wsd_pkg::ST_OK);
                                close_out_frame();
                            end
                            else
                                phase = PAYLOAD;
                        end
                    end
                end
                PAYLOAD:
                begin
                    key_byte  = 8'(key >> {~key_idx, 3'b000});
                    key_idx   = key_idx + 2'd1;
                    remaining = remaining - 1'b1;
                    last      = (remaining == '0);
                    queue_result(b ^ key_byte, 1'b1, last, wsd_pkg::ST_OK);
                    if (last)
                        close_out_frame();
                end
                default:
                    phase = AWAIT_HEAD;
            endcase
        endfunction

        task report(input string what);
            fail_count++;
            $display("mismatch: %s", what);
        endtask

        task check_result(input wsd_pkg::wsd_result_t got);
            wsd_pkg::wsd_result_t want;
            if (want_results.size() == 0)
            begin
                report($sformatf("result %h with nothing pending", got));
                return;
            end
            want = want_results[0];
            want_results.delete(0);
            if (got.data_byte !== want.data_byte)
                report($sformatf("data_byte got %h want %h", got.data_byte, want.data_byte));
            if (got.data_present !== want.data_present)
                report($sformatf("data_present got %b want %b",
                                 got.data_present, want.data_present));
            if (got.frame_opcode !== want.frame_opcode)
                report($sformatf("frame_opcode got %h want %h",
                                 got.frame_opcode, want.frame_opcode));
            if (got.fin_flag !== want.fin_flag)
                report($sformatf("fin_flag got %b want %b", got.fin_flag, want.fin_flag));
            if (got.frame_last !== want.frame_last)
                report($sformatf("frame_last got %b want %b", got.frame_last, want.frame_last));
            if (got.message_last !== want.message_last)
                report($sformatf("message_last got %b want %b",
                                 got.message_last, want.message_last));
            if (got.status !== want.status)
                report($sformatf("status got %0d want %0d", got.status, want.status));
        endtask
    endclass

    logic                      clk;
    logic                      rst_n = 1'b0;
    logic                      cfg_write_en = 1'b0;
    logic [wsd_pkg::LEN_W-1:0] cfg_write_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [7:0]                in_byte = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [7:0]                data_byte;
    logic                      data_present;
    logic [3:0]                frame_opcode;
    logic                      fin_flag;
    logic                      frame_last;
    logic                      message_last;
    logic [2:0]                status;
    wsd_pkg::wsd_result_t      seen;

    deframe_scoreboard sb;
    int unsigned       sent_count;
    int unsigned       cur_limit;
    int unsigned       cycle_count = 0;
    logic              gen_msg;
    logic              tx_calm;

    assign seen = {data_byte, data_present, frame_opcode, fin_flag,
                   frame_last, message_last, status};

    websocket_client_frame_deframer u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_byte        (in_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .data_byte      (data_byte),
        .data_present   (data_present),
        .frame_opcode   (frame_opcode),
        .fin_flag       (fin_flag),
        .frame_last     (frame_last),
        .message_last   (message_last),
        .status         (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("websocket_client_frame_deframer_tb: FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.take_byte(in_byte);
            if (out_valid && out_ready)
                sb.check_result(seen);
        end
    end

    // Receiver: random stalls, calm stretches and a few long hold-offs.
    initial
    begin
        int unsigned stall;
        int unsigned taken;
        int unsigned next_hold;
        int unsigned calm_left;
        taken     = 0;
        next_hold = 150;
        calm_left = 0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (taken == next_hold)
            begin
                stall     = HOLD_CYCLES;
                next_hold = next_hold + 500;
            end
            else if (calm_left > 0)
            begin
                stall     = 0;
                calm_left = calm_left - 1;
            end
            else
            begin
                stall = $urandom_range(0, 3);
                if ($urandom_range(0, 15) == 0)
                    calm_left = $urandom_range(10, 40);
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            taken++;
        end
    end

    task automatic send_byte(input logic [7:0] value);
        int unsigned gap;
        gap = tx_calm ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= value;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent_count++;
    endtask

    task automatic send_header(input logic [3:0] op, input logic fin, input logic mask,
                               input logic [63:0] len, input len_form_t form);
        send_byte({fin, 3'($urandom_range(0, 7)), op});
        case (form)
            LEN_SHORT:
                send_byte({mask, len[6:0]});
            LEN_WIDE16:
            begin
                send_byte({mask, LEN_EXT16});
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end
            default:
            begin
                send_byte({mask, LEN_EXT64});
                for (int i = 7; i >= 0; i--)
                    send_byte(len[8*i +: 8]);
            end
        endcase
    endtask

    task automatic send_frame(input logic [3:0] op, input logic fin, input logic [63:0] len,
                              input len_form_t form, input bit extremes);
        tx_calm = ($urandom_range(0, 4) == 0);
        send_header(op, fin, 1'b1, len, form);
        repeat (4) send_byte(8'($urandom));
        for (int unsigned i = 0; i < len; i++)
            send_byte(extremes ? (i[0] ? 8'hFF : 8'h00) : 8'($urandom));
        if (op == wsd_pkg::OP_TEXT || op == wsd_pkg::OP_BIN)
            gen_msg = 1'b1;
        if (op <= wsd_pkg::OP_BIN && fin)
            gen_msg = 1'b0;
    endtask

    task automatic send_random_frame();
        logic [3:0]  op;
        logic [63:0] len;
        len_form_t   form;
        int unsigned pick;
        int unsigned top;
        pick = $urandom_range(0, 9);
        if (pick < 3)
            op = wsd_pkg::OP_TEXT;
        else if (pick < 6)
            op = wsd_pkg::OP_BIN;
        else if (pick < 8)
            op = gen_msg ? wsd_pkg::OP_CONT : wsd_pkg::OP_TEXT;
        else if (pick == 8)
            op = wsd_pkg::OP_PING;
        else
            op = wsd_pkg::OP_PONG;
        top = (cur_limit < 16) ? cur_limit : 16;
        if ($urandom_range(0, 9) == 0)
            top = (cur_limit < 300) ? cur_limit : 300;
        len = 64'($urandom_range(0, top));
        if ($urandom_range(0, 7) == 0)
            len = 64'(top);
        pick = $urandom_range(0, 5);
        if (len <= 125)
            form = (pick == 0) ? LEN_WIDE16 : (pick == 1) ? LEN_WIDE64 : LEN_SHORT;
        else
            form = (pick < 2) ? LEN_WIDE64 : LEN_WIDE16;
        send_frame(op, 1'($urandom_range(0, 1)), len, form, 1'b0);
    endtask

    task automatic run_frames(input int unsigned target);
        while (sent_count < target)
            send_random_frame();
    endtask

    // Drop valid and wait out every pending result plus the output latency.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.want_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input int unsigned value);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= wsd_pkg::LEN_W'(value);
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        sb.len_limit = wsd_pkg::LEN_W'(value);
        cur_limit    = value;
    endtask

    task automatic send_ending();
        ending_t     kind;
        logic [63:0] len;
        logic [3:0]  op;
        kind    = ending_t'($urandom_range(0, 4));
        tx_calm = 1'b0;
        case (kind)
            END_CLOSE:
            begin
                len = 64'($urandom_range(0, (cur_limit < 8) ? cur_limit : 8));
                send_frame(wsd_pkg::OP_CLOSE, 1'($urandom_range(0, 1)), len, LEN_SHORT, 1'b0);
            end
            END_UNMASKED:
                send_header(4'($urandom), 1'($urandom_range(0, 1)), 1'b0,
                            64'($urandom_range(0, 127)), LEN_SHORT);
            END_TOO_LONG:
            begin
                len = 64'(cur_limit) + 64'd1;
                if ($urandom_range(0, 2) == 0)
                    len = {1'b1, 31'($urandom), 32'($urandom)};
                send_header(4'($urandom), 1'($urandom_range(0, 1)), 1'b1, len,
                            (len <= 125) ? LEN_SHORT :
                            (len < 65536) ? LEN_WIDE16 : LEN_WIDE64);
            end
            END_ORPHAN:
            begin
                if (gen_msg)
                    send_frame(wsd_pkg::OP_BIN, 1'b1, 64'd0, LEN_SHORT, 1'b0);
                send_frame(wsd_pkg::OP_CONT, 1'($urandom_range(0, 1)), 64'd0, LEN_SHORT, 1'b0);
            end
            default:
            begin
                if ($urandom_range(0, 1) == 0)
                    op = 4'($urandom_range(int'(wsd_pkg::OP_BIN) + 1,
                                           int'(wsd_pkg::OP_CLOSE) - 1));
                else
                    op = 4'($urandom_range(int'(wsd_pkg::OP_PONG) + 1, 15));
                send_frame(op, 1'($urandom_range(0, 1)), 64'd0, LEN_SHORT, 1'b0);
            end
        endcase
        repeat (8) send_byte(8'($urandom));
    endtask

    initial
    begin
        sb         = new();
        sent_count = 0;
        gen_msg    = 1'b0;
        tx_calm    = 1'b0;
        cur_limit  = int'(wsd_pkg::MAX_LEN_RESET);
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_frame(wsd_pkg::OP_TEXT, 1'b1, 64'd0, LEN_SHORT, 1'b1);
        send_frame(wsd_pkg::OP_BIN, 1'b0, 64'd2, LEN_SHORT, 1'b1);
        send_frame(wsd_pkg::OP_PING, 1'b1, 64'd0, LEN_SHORT, 1'b1);
        send_frame(wsd_pkg::OP_CONT, 1'b1, 64'd2, LEN_WIDE16, 1'b1);
        run_frames(600);
        settle();

        write_limit(0);
        run_frames(700);
        settle();

        write_limit(LEN_LIMIT_TOP);
        run_frames(1100);
        settle();

        write_limit($urandom_range(1, 40));
        run_frames(1650);
        settle();

        write_limit($urandom_range(0, LEN_LIMIT_TOP));
        send_ending();
        settle();

        if (sb.want_results.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.want_results.size()));
        if (sb.fail_count == 0)
            $display("websocket_client_frame_deframer_tb: PASS");
        else
            $display("websocket_client_frame_deframer_tb: FAIL");
        $finish;
    end

endmodule
